FILE: rtl/core/rsht_pkg.sv
// Shared widths, register indexes and configuration types for the ray-sphere hit test core.
package rsht_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int DIR_FRAC_BITS = 14;

  localparam int DIR_W   = DIR_FRAC_BITS + 2;
  localparam int R_W     = COORD_WIDTH - 1;
  localparam int L_W     = COORD_WIDTH + 1;
  localparam int LD_W    = L_W + DIR_W;
  localparam int P_W     = LD_W + 2;
  localparam int LL_W    = 2 * L_W;
  localparam int LLS_W   = LL_W + 2;
  localparam int RR_W    = 2 * R_W;
  localparam int C_W     = LLS_W + 1;
  localparam int PLO_W   = P_W / 2;
  localparam int PHI_W   = P_W - PLO_W;
  localparam int SQ_W    = 2 * P_W;
  localparam int CS_W    = C_W - 1 + 2 * DIR_FRAC_BITS;
  localparam int CMP_W   = (SQ_W > CS_W) ? SQ_W : CS_W;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X = 2'd0,
    REG_CAMERA_Y = 2'd1,
    REG_CAMERA_Z = 2'd2,
    REG_UNUSED   = 2'd3
  } cfg_reg_t;

endpackage

FILE: rtl/core/rsht_psq.sv
// Two-stage squarer for the magnitude of the ray projection, split into partial products.
module rsht_psq
  import rsht_pkg::*;
(
  input  logic            clk,
  input  logic [P_W-1:0]  pmag,
  output logic [SQ_W-1:0] sq
);

  logic [PHI_W-1:0]       hi;
  logic [PLO_W-1:0]       lo;
  logic [2*PHI_W-1:0]     hh;
  logic [PHI_W+PLO_W-1:0] hl;
  logic [2*PLO_W-1:0]     ll;
  logic [SQ_W-1:0]        sq_next;

  assign hi = pmag[P_W-1:PLO_W];
  assign lo = pmag[PLO_W-1:0];

  always_ff @(posedge clk) begin
    hh <= (2 * PHI_W)'(hi) * (2 * PHI_W)'(hi);
    hl <= (PHI_W + PLO_W)'(hi) * (PHI_W + PLO_W)'(lo);
    ll <= (2 * PLO_W)'(lo) * (2 * PLO_W)'(lo);
  end

  assign sq_next = (SQ_W'(hh) << (2 * PLO_W)) + (SQ_W'(hl) << (PLO_W + 1)) + SQ_W'(ll);

  always_ff @(posedge clk) begin
    sq <= sq_next;
  end

endmodule

FILE: rtl/core/ray_sphere_hit_test_core.sv
// Top level: pipelined ray-sphere hit test with camera origin registers.
// done follows each start transfer through the valid registers v1 to v6 into the done register.
// Throughput: one ray per cycle; seven register stages, busy is low outside reset.
// The deepest path is one 33x33 multiply; the projection square is split over two stages.
// Synchronous reset clears camera registers to zero and empties the pipeline.
// The receiver cannot stall: each result is on hit for exactly one cycle with done.
module ray_sphere_hit_test_core
  import rsht_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [DIR_W-1:0]       dir_x,
  input  logic signed [DIR_W-1:0]       dir_y,
  input  logic signed [DIR_W-1:0]       dir_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  input  logic [R_W-1:0]                sphere_radius,
  output logic                          done,
  output logic                          hit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);

  logic signed [COORD_WIDTH-1:0] camera_x, camera_y, camera_z;
  logic accept;
  logic v1, v2, v3, v4, v5, v6;

  logic signed [L_W-1:0]   lx, ly, lz;
  logic signed [DIR_W-1:0] dx, dy, dz;
  logic [R_W-1:0]          r1;

  logic signed [LD_W-1:0]  ldx, ldy, ldz;
  logic signed [LL_W-1:0]  llx, lly, llz;
  logic [RR_W-1:0]         rr2;

  logic signed [P_W-1:0]   p;
  logic signed [LLS_W-1:0] lls;
  logic [RR_W-1:0]         rr3;

  logic signed [C_W-1:0]   c_next, c4;
  logic [P_W-1:0]          pmag_next, pmag4;
  logic                    pneg4;

  logic [C_W-2:0]          c5, c6;
  logic                    flag5, flag6;
  logic [SQ_W-1:0]         sq;
  logic [CMP_W-1:0]        lhs, rhs;

  assign busy      = rst;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x <= '0;
      camera_y <= '0;
      camera_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAMERA_X: camera_x <= $signed(cfg_data);
        REG_CAMERA_Y: camera_y <= $signed(cfg_data);
        REG_CAMERA_Z: camera_z <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      done <= v6;
    end
  end

  // stage 1: offset from sphere center to camera
  always_ff @(posedge clk) begin
    lx <= L_W'(camera_x) - L_W'(center_x);
    ly <= L_W'(camera_y) - L_W'(center_y);
    lz <= L_W'(camera_z) - L_W'(center_z);
    dx <= dir_x;
    dy <= dir_y;
    dz <= dir_z;
    r1 <= sphere_radius;
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    ldx <= LD_W'(lx) * LD_W'(dx);
    ldy <= LD_W'(ly) * LD_W'(dy);
    ldz <= LD_W'(lz) * LD_W'(dz);
    llx <= LL_W'(lx) * LL_W'(lx);
    lly <= LL_W'(ly) * LL_W'(ly);
    llz <= LL_W'(lz) * LL_W'(lz);
    rr2 <= RR_W'(r1) * RR_W'(r1);
  end

  // stage 3: dot products
  always_ff @(posedge clk) begin
    p   <= P_W'(ldx) + P_W'(ldy) + P_W'(ldz);
    lls <= LLS_W'(llx) + LLS_W'(lly) + LLS_W'(llz);
    rr3 <= rr2;
  end

  // stage 4: c and projection magnitude
  assign c_next    = C_W'(lls) - C_W'($signed({1'b0, rr3}));
  assign pmag_next = p[P_W-1] ? P_W'(-p) : P_W'(p);

  always_ff @(posedge clk) begin
    c4    <= c_next;
    pmag4 <= pmag_next;
    pneg4 <= p[P_W-1];
  end

  // stages 5 and 6: square of projection, side data kept in step
  rsht_psq u_psq (
    .clk  (clk),
    .pmag (pmag4),
    .sq   (sq)
  );

  always_ff @(posedge clk) begin
    c5    <= c4[C_W-2:0];
    flag5 <= pneg4 && !c4[C_W-1] && (c4 != '0);
    c6    <= c5;
    flag6 <= flag5;
  end

  // stage 7: p*p >= c scaled to the projection's fraction bits
  assign lhs = CMP_W'(sq);
  assign rhs = CMP_W'({c6, {(2 * DIR_FRAC_BITS){1'b0}}});

  always_ff @(posedge clk) begin
    hit <= flag6 && (lhs >= rhs);
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##7 done)
    else $error("accepted ray produced no result after 7 cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 7))
    else $error("result strobe without a matching transfer");

  a_hit_flag: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> $past(flag6))
    else $error("hit reported without negative projection and positive c");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy && cfg_ready)
    else $error("core refused a transfer outside reset");

endmodule

FILE: dv/testbench.sv
// Scoreboard-checked random and directed testbench for the ray-sphere hit test core.
module testbench;
  import rsht_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic signed [DIR_W-1:0]       dx;
    logic signed [DIR_W-1:0]       dy;
    logic signed [DIR_W-1:0]       dz;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic [R_W-1:0]                r;
  } ray_t;

  typedef enum int {RAY_RAW, RAY_NEAR, RAY_AIMED} ray_kind_t;

  class hit_scoreboard;
    logic signed [COORD_WIDTH-1:0] camera [3];
    bit hit_q [$];
    int errors;
    int hits;
    int misses;

    function new();
      camera[0] = '0;
      camera[1] = '0;
      camera[2] = '0;
      errors = 0;
      hits = 0;
      misses = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [COORD_WIDTH-1:0] val);
      case (idx)
        REG_CAMERA_X: camera[0] = val;
        REG_CAMERA_Y: camera[1] = val;
        REG_CAMERA_Z: camera[2] = val;
        default: ;
      endcase
    endfunction

    function bit predict_hit(ray_t ray);
      logic signed [127:0] l0, l1, l2, d0, d1, d2;
      logic signed [127:0] p, ll, rr, c, sq, cs;
      l0 = $signed(camera[0]) - $signed(ray.cx);
      l1 = $signed(camera[1]) - $signed(ray.cy);
      l2 = $signed(camera[2]) - $signed(ray.cz);
      d0 = $signed(ray.dx);
      d1 = $signed(ray.dy);
      d2 = $signed(ray.dz);
      rr = ray.r;
      rr = rr * rr;
      p  = l0 * d0 + l1 * d1 + l2 * d2;
      ll = l0 * l0 + l1 * l1 + l2 * l2;
      c  = ll - rr;
      sq = p * p;
      cs = c <<< (2 * DIR_FRAC_BITS);
      return (p < 0) && (c > 0) && (sq >= cs);
    endfunction

    function void add_ray(ray_t ray);
      bit h;
      h = predict_hit(ray);
      hit_q.push_back(h);
      if (h) hits++;
      else misses++;
    endfunction

    function void check_hit(logic actual);
      bit exp_hit;
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected result, no ray pending: expected none, actual hit=%b",
                 $time, actual);
        errors++;
      end else begin
        exp_hit = hit_q.pop_front();
        if (actual !== exp_hit) begin
          $display("%0t: hit mismatch: expected %b, actual %b", $time, exp_hit, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return hit_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [DIR_W-1:0] dir_x = '0;
  logic signed [DIR_W-1:0] dir_y = '0;
  logic signed [DIR_W-1:0] dir_z = '0;
  logic signed [COORD_WIDTH-1:0] center_x = '0;
  logic signed [COORD_WIDTH-1:0] center_y = '0;
  logic signed [COORD_WIDTH-1:0] center_z = '0;
  logic [R_W-1:0] sphere_radius = '0;
  logic done;
  logic hit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_WIDTH-1:0] cfg_data = '0;

  hit_scoreboard sb;
  int idle_cycles = 0;
  int settings_run = 0;
  bit no_gap_burst = 1'b0;

  ray_sphere_hit_test_core u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .dir_z        (dir_z),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_z     (center_z),
    .sphere_radius(sphere_radius),
    .done         (done),
    .hit          (hit),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_hit(hit);
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic ray_t mk_ray(int dx, int dy, int dz, int cx, int cy, int cz, int r);
    ray_t ray;
    ray.dx = DIR_W'(dx);
    ray.dy = DIR_W'(dy);
    ray.dz = DIR_W'(dz);
    ray.cx = cx;
    ray.cy = cy;
    ray.cz = cz;
    ray.r  = R_W'(r);
    return ray;
  endfunction

  function automatic ray_t random_ray(ray_kind_t kind);
    ray_t ray;
    int off [3];
    int mag;
    if (kind == RAY_RAW) begin
      ray.dx = DIR_W'($urandom);
      ray.dy = DIR_W'($urandom);
      ray.dz = DIR_W'($urandom);
      ray.cx = $urandom;
      ray.cy = $urandom;
      ray.cz = $urandom;
      ray.r  = R_W'($urandom);
      return ray;
    end
    for (int i = 0; i < 3; i++) off[i] = int'($urandom_range(0, 8388607)) - 4194304;
    ray.cx = sb.camera[0] + off[0];
    ray.cy = sb.camera[1] + off[1];
    ray.cz = sb.camera[2] + off[2];
    if (kind == RAY_NEAR) begin
      ray.dx = DIR_W'(int'($urandom_range(0, 32767)) - 16384);
      ray.dy = DIR_W'(int'($urandom_range(0, 32767)) - 16384);
      ray.dz = DIR_W'(int'($urandom_range(0, 32767)) - 16384);
      ray.r  = R_W'($urandom_range(0, 2097152));
    end else begin
      mag = $urandom_range(0, 9459);
      ray.dx = DIR_W'((off[0] >= 0) ? mag : -mag);
      mag = $urandom_range(0, 9459);
      ray.dy = DIR_W'((off[1] >= 0) ? mag : -mag);
      mag = $urandom_range(0, 9459);
      ray.dz = DIR_W'((off[2] >= 0) ? mag : -mag);
      ray.r  = R_W'($urandom_range(0, 4194304));
    end
    return ray;
  endfunction

  function automatic int draw_gap();
    return no_gap_burst ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic send_ray(ray_t ray);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    dir_x         <= ray.dx;
    dir_y         <= ray.dy;
    dir_z         <= ray.dz;
    center_x      <= ray.cx;
    center_y      <= ray.cy;
    center_z      <= ray.cz;
    sphere_radius <= ray.r;
    do @(posedge clk); while (busy);
    sb.add_ray(ray);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [COORD_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_camera(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y,
                            logic [COORD_WIDTH-1:0] z);
    write_reg(REG_CAMERA_X, x);
    write_reg(REG_CAMERA_Y, y);
    write_reg(REG_UNUSED, $urandom);
    write_reg(REG_CAMERA_Z, z);
    settings_run++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_rays(int count);
    ray_kind_t kind;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) no_gap_burst = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: kind = RAY_RAW;
        1: kind = RAY_NEAR;
        default: kind = RAY_AIMED;
      endcase
      send_ray(random_ray(kind));
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // camera at reset origin
    settings_run = 1;
    send_ray(mk_ray(0, 0, 0, 5 << 16, 0, 0, 1 << 16));
    send_ray(mk_ray(16384, 0, 0, 5 << 16, 1 << 16, 0, 1 << 16));
    send_ray(mk_ray(-16384, 0, 0, 5 << 16, 1 << 16, 0, 1 << 16));
    send_ray(mk_ray(16384, 0, 0, 0, 0, 0, 1 << 16));
    send_ray(mk_ray(16384, 0, 0, 1 << 16, 0, 0, 1 << 16));
    send_ray(mk_ray(16384, 0, 0, 10 << 16, 0, 0, 2 << 16));
    send_ray(mk_ray(-16384, 0, 0, 10 << 16, 0, 0, 2 << 16));
    send_ray(mk_ray(16384, 0, 0, 10 << 16, 3 << 16, 0, 2 << 16));
    send_ray(mk_ray(32767, 0, 0, 10 << 16, 0, 0, 2 << 16));
    send_ray(mk_ray(0, 0, -16384, 0, 0, -(7 << 16), 3 << 16));
    send_ray(mk_ray(-32768, -32768, -32768, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 31'h7fff_ffff));
    send_ray(mk_ray(32767, 32767, 32767, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff, 31'h7fff_ffff));
    send_ray(mk_ray(-32768, -32768, -32768, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 0));
    send_ray(mk_ray(32767, 32767, 32767, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff, 0));
    send_ray(mk_ray(-32768, 32767, -32768, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 0));
    send_ray(mk_ray(16384, 0, 0, 0, 0, 0, 31'h7fff_ffff));
    send_ray(mk_ray(9459, 9459, 9459, 4 << 16, 4 << 16, 4 << 16, 1 << 16));
    send_ray(mk_ray(-1, 0, 0, -(1 << 16), 0, 0, 0));
    random_rays(100);
    drain();

    set_camera($urandom_range(0, 8388607) - 4194304, $urandom_range(0, 8388607) - 4194304,
               $urandom_range(0, 8388607) - 4194304);
    random_rays(130);
    drain();

    set_camera(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    send_ray(mk_ray(-16384, 0, 0, 32'h7ff0_0000, 32'h8000_0000, 0, 1 << 16));
    send_ray(mk_ray(16384, 0, 0, 32'h7ff0_0000, 32'h8000_0000, 0, 1 << 16));
    random_rays(120);
    drain();

    set_camera(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    random_rays(60);
    drain();

    set_camera($urandom, $urandom, $urandom);
    random_rays(70);
    drain();

    $display("Covered %0d rays (%0d hits, %0d misses) over %0d camera settings",
             sb.hits + sb.misses, sb.hits, sb.misses, settings_run);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/rsht_pkg.sv
rtl/core/rsht_psq.sv
rtl/core/ray_sphere_hit_test_core.sv
dv/testbench.sv
